/* src/eht_pkg.sv */
// Shared types, constants and a helper function of the extendible hash table.
package eht_pkg;

  localparam int MAX_DEPTH    = 6;
  localparam int BUCKET_SLOTS = 8;
  localparam int KEY_BITS     = 32;
  localparam int DIR_SIZE     = 1 << MAX_DEPTH;
  localparam int SLOT_COUNT   = DIR_SIZE * BUCKET_SLOTS;
  localparam int DIR_AW       = $clog2(DIR_SIZE);
  localparam int SLOT_AW      = $clog2(BUCKET_SLOTS);
  localparam int FILL_W       = $clog2(BUCKET_SLOTS + 1);
  localparam int DEPTH_W      = 3;
  localparam int CNT_W        = DIR_AW + 1;
  localparam int META_W       = DEPTH_W + FILL_W;
  localparam int SLOT_W       = 2 * KEY_BITS;

  localparam logic [31:0] FNV_BASIS = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NOP    = 2'd3
  } eht_kind_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_SPLIT_OK  = 3'd1,
    ST_DIR_FULL  = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_CLEARED   = 3'd6
  } eht_status_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_HASH, S_DIR, S_META,
    S_LK_RD, S_LK_CMP, S_LK_END,
    S_DBL_RD, S_DBL_WR, S_SPLIT, S_FIND_RD, S_FIND_CMP, S_SPAN, S_PTR_WR,
    S_REC_RD, S_REC_GO, S_REC_WAIT, S_NEW_GO, S_NEW_WAIT, S_META_B, S_META_NB
  } eht_state_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic signed [31:0]   key;
    logic [31:0]          payload;
  } eht_in_t;

  typedef struct packed {
    eht_status_t          status;
    logic signed [31:0]   found_key;
    logic [31:0]          found_payload;
    logic                 last;
  } eht_out_t;

  typedef struct packed {
    logic                 start;
    logic [31:0]          key;
    logic [DEPTH_W-1:0]   depth;
  } eht_hash_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIR_AW-1:0]    index;
  } eht_hash_rsp_t;

  // Top depth bits of the hash; depth zero always gives index zero.
  function automatic logic [DIR_AW-1:0] hash_top(input logic [31:0] h,
                                                 input logic [DEPTH_W-1:0] d);
    logic [31:0] sh;
    sh = h >> (6'd32 - {3'd0, d});
    if (d == '0) return '0;
    return sh[DIR_AW-1:0];
  endfunction

endpackage

/* src/eht_ram.sv */
// Generic single write port memory with registered read.
module eht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/eht_hash.sv */
// Iterative FNV-1a style unit, one key byte per cycle, then the directory index.
module eht_hash (
  input  logic                   clk,
  input  logic                   rst_n,
  input  eht_pkg::eht_hash_req_t req,
  output eht_pkg::eht_hash_rsp_t rsp
);
  import eht_pkg::*;

  logic [31:0]        h_r, h_nxt;
  logic [31:0]        key_r;
  logic [DEPTH_W-1:0] depth_r;
  logic [2:0]         step_r, step_nxt;
  logic               run_r, run_nxt;
  logic               done_r, done_nxt;
  logic [DIR_AW-1:0]  idx_r, idx_nxt;
  logic [7:0]         byte_sel;
  logic [31:0]        byte_ext;

  assign byte_sel = key_r[{step_r[1:0], 3'b000} +: 8];
  assign byte_ext = {{24{byte_sel[7]}}, byte_sel};

  always_comb begin
    h_nxt    = h_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    idx_nxt  = idx_r;
    if (req.start) begin
      h_nxt    = FNV_BASIS;
      step_nxt = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (step_r == 3'd4) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
        idx_nxt  = hash_top(h_r, depth_r);
      end else begin
        h_nxt    = (h_r ^ byte_ext) * FNV_PRIME;
        step_nxt = step_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    h_r   <= h_nxt;
    idx_r <= idx_nxt;
    if (req.start) begin
      key_r   <= req.key;
      depth_r <= req.depth;
    end
  end

  assign rsp.done  = done_r;
  assign rsp.index = idx_r;

endmodule

/* src/extendible_hash_table.sv */
// Top level of the extendible hash table: sequencer, directory, bucket and slot memories.
//
//  channel  | handshake          | beat
//  ---------+--------------------+---------------------------------------------
//  input    | start, busy        | in_item: kind, key, payload
//  result   | out_strobe         | out_item: status, found_key, found_payload, last
//  config   | cfg_we             | cfg_wdata: initial_depth
//
// A beat is taken at an edge where start is high and busy is low. Each operation is
// walked through by one sequencer that shares a single iterative FNV-1a style unit
// (four byte steps and an index step) and single write port memories with registered
// reads. A lookup reads the filled slots of its bucket one after another. An insert
// that splits adds the directory doubling when needed, the owner search over the
// directory, the pointer rewrite, and a re-hash of each record. A clear writes the
// buckets it builds one after another. After reset the block builds bucket zero,
// with busy high. Results come as single-cycle strobes; the receiver cannot hold
// them off.
module extendible_hash_table (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  eht_pkg::eht_in_t       in_item,
  output logic                   out_strobe,
  output eht_pkg::eht_out_t      out_item,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_wdata
);
  import eht_pkg::*;

  eht_state_t         state_r, state_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic [31:0]        key_r, key_nxt;
  logic [31:0]        pay_r, pay_nxt;
  logic [DEPTH_W-1:0] clr_depth_r, clr_depth_nxt;
  logic               reply_r, reply_nxt;
  logic [DEPTH_W-1:0] gd_r, gd_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [DEPTH_W-1:0] init_r;
  logic [DIR_AW-1:0]  b_r, b_nxt;
  logic [DIR_AW-1:0]  nb_r, nb_nxt;
  logic [DEPTH_W-1:0] ld_r, ld_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [CNT_W-1:0]   first_r, first_nxt;
  logic [CNT_W-1:0]   half_r, half_nxt;
  logic [CNT_W-1:0]   end_r, end_nxt;
  logic [FILL_W-1:0]  fb_r, fb_nxt;
  logic [FILL_W-1:0]  fn_r, fn_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [31:0]        pend_key_r, pend_key_nxt;
  logic [31:0]        pend_pay_r, pend_pay_nxt;
  eht_status_t        ins_st_r, ins_st_nxt;
  logic               out_v_r, out_v_nxt;
  eht_out_t           out_r, out_nxt;

  // Memory ports.
  logic                dir_we;
  logic [DIR_AW-1:0]   dir_waddr, dir_raddr, dir_wdata, dir_rdata;
  logic                meta_we;
  logic [DIR_AW-1:0]   meta_waddr, meta_raddr;
  logic [META_W-1:0]   meta_wdata, meta_rdata;
  logic                slot_we;
  logic [DIR_AW+SLOT_AW-1:0] slot_waddr, slot_raddr;
  logic [SLOT_W-1:0]   slot_wdata, slot_rdata;

  eht_hash_req_t       hreq;
  eht_hash_rsp_t       hrsp;

  logic [DEPTH_W-1:0]  meta_ld;
  logic [FILL_W-1:0]   meta_fill;
  logic [31:0]         slot_key, slot_pay;
  logic                accept;
  logic [DEPTH_W-1:0]  init_sat;
  logic [CNT_W-1:0]    clr_n;
  logic [CNT_W-1:0]    span;
  logic                to_b;
  logic [FILL_W-1:0]   tgt_cnt;

  assign meta_ld   = meta_rdata[META_W-1 -: DEPTH_W];
  assign meta_fill = meta_rdata[FILL_W-1:0];
  assign slot_key  = slot_rdata[SLOT_W-1 -: 32];
  assign slot_pay  = slot_rdata[31:0];
  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign init_sat  = (init_r > DEPTH_W'(MAX_DEPTH)) ? DEPTH_W'(MAX_DEPTH) : init_r;
  assign clr_n     = CNT_W'(1) << clr_depth_r;
  assign span      = CNT_W'(1) << (gd_r - ld_r);
  // Records whose index falls in the lower half of the old span stay in the old bucket.
  assign to_b      = ({1'b0, hrsp.index} <= half_r);
  assign tgt_cnt   = to_b ? fb_r : fn_r;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    clr_depth_nxt = clr_depth_r;
    reply_nxt     = reply_r;
    gd_nxt        = gd_r;
    used_nxt      = used_r;
    b_nxt         = b_r;
    nb_nxt        = nb_r;
    ld_nxt        = ld_r;
    fill_nxt      = fill_r;
    first_nxt     = first_r;
    half_nxt      = half_r;
    end_nxt       = end_r;
    fb_nxt        = fb_r;
    fn_nxt        = fn_r;
    pend_v_nxt    = pend_v_r;
    pend_key_nxt  = pend_key_r;
    pend_pay_nxt  = pend_pay_r;
    ins_st_nxt    = ins_st_r;
    out_v_nxt     = 1'b0;
    out_nxt       = out_r;

    dir_we     = 1'b0;
    dir_waddr  = idx_r[DIR_AW-1:0];
    dir_wdata  = idx_r[DIR_AW-1:0];
    dir_raddr  = idx_r[DIR_AW-1:0];
    meta_we    = 1'b0;
    meta_waddr = b_r;
    meta_wdata = {ld_r, fill_r};
    meta_raddr = b_r;
    slot_we    = 1'b0;
    slot_waddr = {b_r, fill_r[SLOT_AW-1:0]};
    slot_wdata = {key_r, pay_r};
    slot_raddr = {b_r, idx_r[SLOT_AW-1:0]};

    hreq.start = 1'b0;
    hreq.key   = key_r;
    hreq.depth = gd_r;

    case (state_r)
      S_CLR: begin
        // Build one bucket per cycle: pointer to itself, configured depth, empty.
        dir_we     = 1'b1;
        meta_we    = 1'b1;
        meta_waddr = idx_r[DIR_AW-1:0];
        meta_wdata = {clr_depth_r, FILL_W'(0)};
        if (idx_r == clr_n - CNT_W'(1)) begin
          gd_nxt    = clr_depth_r;
          used_nxt  = clr_n;
          state_nxt = S_IDLE;
          if (reply_r) begin
            out_v_nxt = 1'b1;
            out_nxt   = '{ST_CLEARED, key_r, 32'd0, 1'b1};
          end
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          kind_nxt = in_item.kind;
          key_nxt  = in_item.key;
          pay_nxt  = in_item.payload;
          case (in_item.kind)
            KIND_INSERT, KIND_LOOKUP: begin
              hreq.start = 1'b1;
              hreq.key   = in_item.key;
              state_nxt  = S_HASH;
            end
            KIND_CLEAR: begin
              clr_depth_nxt = init_sat;
              idx_nxt       = '0;
              reply_nxt     = 1'b1;
              state_nxt     = S_CLR;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_HASH: begin
        dir_raddr = hrsp.index;
        if (hrsp.done) begin
          state_nxt = S_DIR;
        end
      end
      S_DIR: begin
        b_nxt      = dir_rdata;
        meta_raddr = dir_rdata;
        state_nxt  = S_META;
      end
      S_META: begin
        ld_nxt   = meta_ld;
        fill_nxt = meta_fill;
        idx_nxt  = '0;
        if (kind_r == KIND_LOOKUP) begin
          pend_v_nxt = 1'b0;
          if (meta_fill == '0) begin
            out_v_nxt = 1'b1;
            out_nxt   = '{ST_NOT_FOUND, key_r, 32'd0, 1'b1};
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_LK_RD;
          end
        end else if (meta_fill != FILL_W'(BUCKET_SLOTS)) begin
          slot_we    = 1'b1;
          slot_waddr = {b_r, meta_fill[SLOT_AW-1:0]};
          meta_we    = 1'b1;
          meta_wdata = {meta_ld, meta_fill + FILL_W'(1)};
          out_v_nxt  = 1'b1;
          out_nxt    = '{ST_INSERTED, key_r, 32'd0, 1'b1};
          state_nxt  = S_IDLE;
        end else if (meta_ld >= gd_r) begin
          if (gd_r >= DEPTH_W'(MAX_DEPTH)) begin
            out_v_nxt = 1'b1;
            out_nxt   = '{ST_DIR_FULL, key_r, 32'd0, 1'b1};
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = (CNT_W'(2) << gd_r) - CNT_W'(1);
            state_nxt = S_DBL_RD;
          end
        end else begin
          state_nxt = S_SPLIT;
        end
      end
      S_LK_RD: begin
        state_nxt = S_LK_CMP;
      end
      S_LK_CMP: begin
        if (slot_key == key_r) begin
          // A newer match proves the held one is not the final result.
          if (pend_v_r) begin
            out_v_nxt = 1'b1;
            out_nxt   = '{ST_FOUND, pend_key_r, pend_pay_r, 1'b0};
          end
          pend_v_nxt   = 1'b1;
          pend_key_nxt = slot_key;
          pend_pay_nxt = slot_pay;
        end
        idx_nxt = idx_r + CNT_W'(1);
        if (idx_r + CNT_W'(1) == CNT_W'(fill_r)) begin
          state_nxt = S_LK_END;
        end else begin
          state_nxt = S_LK_RD;
        end
      end
      S_LK_END: begin
        out_v_nxt = 1'b1;
        if (pend_v_r) begin
          out_nxt = '{ST_FOUND, pend_key_r, pend_pay_r, 1'b1};
        end else begin
          out_nxt = '{ST_NOT_FOUND, key_r, 32'd0, 1'b1};
        end
        state_nxt = S_IDLE;
      end
      S_DBL_RD: begin
        dir_raddr = idx_r[CNT_W-1:1];
        state_nxt = S_DBL_WR;
      end
      S_DBL_WR: begin
        // Walking downwards, each entry copies its parent before the parent is touched.
        dir_we    = 1'b1;
        dir_wdata = dir_rdata;
        if (idx_r == '0) begin
          gd_nxt    = gd_r + DEPTH_W'(1);
          state_nxt = S_SPLIT;
        end else begin
          idx_nxt   = idx_r - CNT_W'(1);
          state_nxt = S_DBL_RD;
        end
      end
      S_SPLIT: begin
        if (used_r >= CNT_W'(DIR_SIZE)) begin
          out_v_nxt = 1'b1;
          out_nxt   = '{ST_DIR_FULL, key_r, 32'd0, 1'b1};
          state_nxt = S_IDLE;
        end else begin
          nb_nxt    = used_r[DIR_AW-1:0];
          used_nxt  = used_r + CNT_W'(1);
          idx_nxt   = '0;
          state_nxt = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        state_nxt = S_FIND_CMP;
      end
      S_FIND_CMP: begin
        if (dir_rdata == b_r) begin
          first_nxt = idx_r;
          state_nxt = S_SPAN;
        end else if (idx_r + CNT_W'(1) == (CNT_W'(1) << gd_r)) begin
          first_nxt = CNT_W'(1) << gd_r;
          state_nxt = S_SPAN;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_FIND_RD;
        end
      end
      S_SPAN: begin
        half_nxt  = first_r + (span >> 1) - CNT_W'(1);
        end_nxt   = first_r + span - CNT_W'(1);
        idx_nxt   = first_r + (span >> 1);
        state_nxt = S_PTR_WR;
      end
      S_PTR_WR: begin
        if (idx_r <= end_r && idx_r < CNT_W'(DIR_SIZE)) begin
          dir_we    = 1'b1;
          dir_wdata = nb_r;
          idx_nxt   = idx_r + CNT_W'(1);
        end else begin
          fb_nxt    = '0;
          fn_nxt    = '0;
          idx_nxt   = '0;
          state_nxt = S_REC_RD;
        end
      end
      S_REC_RD: begin
        state_nxt = S_REC_GO;
      end
      S_REC_GO: begin
        // Keep the record in the pending registers while its hash runs.
        pend_key_nxt = slot_key;
        pend_pay_nxt = slot_pay;
        hreq.start   = 1'b1;
        hreq.key     = slot_key;
        state_nxt    = S_REC_WAIT;
      end
      S_REC_WAIT: begin
        if (hrsp.done) begin
          slot_we    = 1'b1;
          slot_waddr = {to_b ? b_r : nb_r, tgt_cnt[SLOT_AW-1:0]};
          slot_wdata = {pend_key_r, pend_pay_r};
          if (to_b) begin
            fb_nxt = fb_r + FILL_W'(1);
          end else begin
            fn_nxt = fn_r + FILL_W'(1);
          end
          idx_nxt = idx_r + CNT_W'(1);
          if (idx_r + CNT_W'(1) == CNT_W'(fill_r)) begin
            state_nxt = S_NEW_GO;
          end else begin
            state_nxt = S_REC_RD;
          end
        end
      end
      S_NEW_GO: begin
        hreq.start = 1'b1;
        state_nxt  = S_NEW_WAIT;
      end
      S_NEW_WAIT: begin
        if (hrsp.done) begin
          if (tgt_cnt == FILL_W'(BUCKET_SLOTS)) begin
            ins_st_nxt = ST_OVERFLOW;
          end else begin
            slot_we    = 1'b1;
            slot_waddr = {to_b ? b_r : nb_r, tgt_cnt[SLOT_AW-1:0]};
            ins_st_nxt = ST_SPLIT_OK;
            if (to_b) begin
              fb_nxt = fb_r + FILL_W'(1);
            end else begin
              fn_nxt = fn_r + FILL_W'(1);
            end
          end
          state_nxt = S_META_B;
        end
      end
      S_META_B: begin
        meta_we    = 1'b1;
        meta_wdata = {ld_r + DEPTH_W'(1), fb_r};
        state_nxt  = S_META_NB;
      end
      S_META_NB: begin
        meta_we    = 1'b1;
        meta_waddr = nb_r;
        meta_wdata = {ld_r + DEPTH_W'(1), fn_r};
        out_v_nxt  = 1'b1;
        out_nxt    = '{ins_st_r, key_r, 32'd0, 1'b1};
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      clr_depth_r <= '0;
      reply_r     <= 1'b0;
      gd_r        <= '0;
      used_r      <= CNT_W'(1);
      init_r      <= '0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      clr_depth_r <= clr_depth_nxt;
      reply_r     <= reply_nxt;
      gd_r        <= gd_nxt;
      used_r      <= used_nxt;
      pend_v_r    <= pend_v_nxt;
      out_v_r     <= out_v_nxt;
      if (cfg_we) begin
        init_r <= cfg_wdata;
      end
    end
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    pay_r      <= pay_nxt;
    b_r        <= b_nxt;
    nb_r       <= nb_nxt;
    ld_r       <= ld_nxt;
    fill_r     <= fill_nxt;
    first_r    <= first_nxt;
    half_r     <= half_nxt;
    end_r      <= end_nxt;
    fb_r       <= fb_nxt;
    fn_r       <= fn_nxt;
    pend_key_r <= pend_key_nxt;
    pend_pay_r <= pend_pay_nxt;
    ins_st_r   <= ins_st_nxt;
    out_r      <= out_nxt;
  end

  assign out_strobe = out_v_r;
  assign out_item   = out_r;

  eht_hash u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (hreq),
    .rsp   (hrsp)
  );

  // Directory: bucket number for each index.
  eht_ram #(.WIDTH(DIR_AW), .DEPTH(DIR_SIZE)) u_dir (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  // Bucket metadata: local depth and fill count.
  eht_ram #(.WIDTH(META_W), .DEPTH(DIR_SIZE)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // Record slots: key and payload, addressed by bucket and slot.
  eht_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_slot (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

`ifndef NO_ASSERTIONS
  // The bucket count never exceeds the directory size at the current global depth.
  a_used_le_dir: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= (CNT_W'(1) << gd_r))
    else $error("bucket count exceeds directory size");

  // An unused command kind produces no result beat.
  a_nop_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_item.kind == KIND_NOP) |=> !out_strobe)
    else $error("result beat for an ignored command");

  // The hash unit only reports while the sequencer is waiting for it.
  a_hash_wait: assert property (@(posedge clk) disable iff (!rst_n)
    hrsp.done |-> (state_r == S_HASH || state_r == S_REC_WAIT || state_r == S_NEW_WAIT))
    else $error("hash result outside a wait state");

  // A result beat always follows a cycle in which an operation was in progress.
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without an operation in progress");
`endif

endmodule
